### rtl/btg_pkg.sv
// Shared types, constants and table builder for the binaural tone generator.
// No dependencies; btg_sine_rom, btg_divider and the top level import this package.
package btg_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_CARRIER_STEP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BEAT_STEP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_FRAMES = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE    = 3'd4;

    localparam int FRAME_BITS = 32;
    localparam int AMP_BITS   = 15;

    localparam logic [31:0]         CARRIER_STEP_RST = 32'd15713773;
    localparam logic [31:0]         BEAT_STEP_RST    = 32'd268435;
    localparam logic [31:0]         TOTAL_FRAMES_RST = 32'd48000;
    localparam logic [31:0]         FADE_FRAMES_RST  = 32'd4800;
    localparam logic [AMP_BITS-1:0] AMPLITUDE_RST    = 15'd16384;

    // Envelope: unsigned, 1.0 == 2^15
    localparam int               ENV_FRAC_BITS = 15;
    localparam int               ENV_BITS      = ENV_FRAC_BITS + 1;
    localparam logic [ENV_BITS-1:0] ENV_ONE    = 16'h8000;

    // Sine magnitude in Q15
    localparam int SINE_MAG_BITS = 15;
    localparam int PROD1_BITS    = SINE_MAG_BITS + AMP_BITS;
    localparam int PROD2_BITS    = PROD1_BITS + ENV_BITS;

    // Entries of the state memory
    localparam int ENT_COUNT = 4;
    localparam int ENT_BITS  = 2;
    localparam logic [ENT_BITS-1:0] ENT_FRAME  = 2'd0;
    localparam logic [ENT_BITS-1:0] ENT_LPHASE = 2'd1;
    localparam logic [ENT_BITS-1:0] ENT_RPHASE = 2'd2;
    localparam logic [ENT_BITS-1:0] ENT_FADE   = 2'd3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic busy;
        logic done;
    } btg_div_status_t;

    // Quarter-wave sine entry k for a table of 2^(sib-2) steps per quarter.
    // Integer Taylor series in Q30 up to x^17, each term truncated, then
    // rounded to Q15 and capped. Evaluated at elaboration only.
    function automatic logic [SINE_MAG_BITS-1:0] sine_q15(input int unsigned k,
                                                        input int unsigned sib);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        int          n;
        x    = (64'(k) * HALF_PI_Q30) >> (sib - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if ((n % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[SINE_MAG_BITS-1:0];
    endfunction

endpackage

### rtl/btg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module btg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/btg_sine_rom.sv
// Quarter-wave Q15 sine table with registered read.
// Depends on btg_pkg (sine_q15 builds the contents at elaboration).
module btg_sine_rom import btg_pkg::*; #(
    parameter int SINE_INDEX_BITS = 12
) (
    input  logic                       aclk,
    input  logic [SINE_INDEX_BITS-2:0] addr,
    output logic [SINE_MAG_BITS-1:0]   rdata
);

    localparam int DEPTH = (1 << (SINE_INDEX_BITS - 2)) + 1;

    logic [SINE_MAG_BITS-1:0] rom_mem [DEPTH];
    logic [SINE_MAG_BITS-1:0] rdata_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign rom_mem[k] = sine_q15(k, SINE_INDEX_BITS);
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= rom_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/btg_divider.sv
// Restoring divider for the envelope: floor(num * 2^15 / den), num < den.
// One quotient bit per cycle. Depends on btg_pkg.
module btg_divider import btg_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [FRAME_BITS-1:0]    num,
    input  logic [FRAME_BITS-1:0]    den,
    output logic [ENV_FRAC_BITS-1:0] quotient,
    output btg_div_status_t          status
);

    localparam int CNT_BITS = $clog2(ENV_FRAC_BITS + 1);

    logic [FRAME_BITS-1:0]    rem_reg,  rem_next;
    logic [FRAME_BITS-1:0]    den_reg,  den_next;
    logic [ENV_FRAC_BITS-1:0] quo_reg,  quo_next;
    logic [CNT_BITS-1:0]      cnt_reg,  cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [FRAME_BITS:0] shifted;
    logic [FRAME_BITS:0] diff;
    logic                fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CNT_BITS'(ENV_FRAC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // subtract when the shifted remainder covers the divisor
            rem_next = fits ? diff[FRAME_BITS-1:0] : shifted[FRAME_BITS-1:0];
            quo_next = {quo_reg[ENV_FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/binaural_tone_generator_top.sv
// Binaural tone generator, top level: configuration registers, frame sequencer,
// state memory, sine table, envelope divider and output register.
// Depends on btg_pkg, btg_ram, btg_sine_rom and btg_divider.
//
// Each transfer on the s_ channel requests one stereo frame and yields exactly
// one transfer on the m_ channel. The left sample is a sine at carrier_step
// per frame, the right one at carrier_step + beat_step; both are scaled by
// amplitude (Q15) and by a linear fade envelope, truncated toward zero. A
// transfer with s_restart set begins a new run at frame zero with both phases
// zero and latches the fade length (clamped to half of total_frames); after
// the last frame, or before any run, frames come out as zeros with m_finished
// set. Frames are handled one at a time: the frame counter, both phase
// accumulators and the latched fade length live in a four-entry memory that is
// read entry by entry at the start of a frame and written back at its end, so
// no frame ever sees a stale entry. From accept to result loaded, a finished
// frame goes straight to the output; a continuing frame reads the four state
// entries, runs the bit-serial envelope divider when fading, passes the left
// and then the right sample through the sine table and two multipliers, and
// makes four write backs; a restart frame skips the reads. A new frame is
// accepted as soon as the sequencer is back in idle, even while the previous
// result waits in the output register. Configuration writes take effect at once,
// except fade_frames, which acts at the next restart; write only while idle.

module binaural_tone_generator_top import btg_pkg::*; #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_INDEX_BITS = 12,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    // frame request
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    // frame result
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_sample,
    output logic signed [SAMPLE_BITS-1:0] m_right_sample,
    output logic                          m_last_frame,
    output logic                          m_finished
);

    // State memory word holds either a frame count or a phase
    localparam int STATE_W  = (PHASE_BITS > FRAME_BITS) ? PHASE_BITS : FRAME_BITS;
    localparam int ROM_AW   = SINE_INDEX_BITS - 1;
    localparam int QUARTER  = 1 << (SINE_INDEX_BITS - 2);
    localparam int RD_CNT_W = $clog2(ENT_COUNT + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_CHECK = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_ROM   = 10'b0000010000,
        ST_MUL1  = 10'b0000100000,
        ST_MUL2  = 10'b0001000000,
        ST_SIGN  = 10'b0010000000,
        ST_WB    = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } btg_state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0]         carrier_step_reg;
    logic [31:0]         beat_step_reg;
    logic [31:0]         total_frames_reg;
    logic [31:0]         fade_frames_reg;
    logic [AMP_BITS-1:0] amplitude_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_step_reg <= CARRIER_STEP_RST;
            beat_step_reg    <= BEAT_STEP_RST;
            total_frames_reg <= TOTAL_FRAMES_RST;
            fade_frames_reg  <= FADE_FRAMES_RST;
            amplitude_reg    <= AMPLITUDE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CARRIER_STEP: carrier_step_reg <= cfg_wdata;
                REG_BEAT_STEP:    beat_step_reg    <= cfg_wdata;
                REG_TOTAL_FRAMES: total_frames_reg <= cfg_wdata;
                REG_FADE_FRAMES:  fade_frames_reg  <= cfg_wdata;
                REG_AMPLITUDE:    amplitude_reg    <= cfg_wdata[AMP_BITS-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer registers
    // ---------------------------------------------------------------
    btg_state_t state_reg, state_next;
    logic       run_done_reg, run_done_next;
    logic [RD_CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [ENT_BITS-1:0] rd_addr_reg, rd_addr_next;
    logic [ENT_BITS-1:0] wb_cnt_reg, wb_cnt_next;
    logic       ch_reg, ch_next;

    // working copy of the frame state
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [PHASE_BITS-1:0] lph_reg, lph_next;
    logic [PHASE_BITS-1:0] rph_reg, rph_next;
    logic [FRAME_BITS-1:0] fade_reg, fade_next;

    // sample datapath
    logic [ENV_BITS-1:0]    env_reg, env_next;
    logic                   neg_reg, neg_next;
    logic [PROD1_BITS-1:0]  prod1_reg, prod1_next;
    logic [PROD2_BITS-1:0]  prod2_reg, prod2_next;
    logic                   last_reg, last_next;
    logic [SAMPLE_BITS-1:0] res_left_reg, res_left_next;
    logic [SAMPLE_BITS-1:0] res_right_reg, res_right_next;
    logic                   res_last_reg, res_last_next;
    logic                   res_fin_reg, res_fin_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_left_reg, m_left_next;
    logic [SAMPLE_BITS-1:0] m_right_reg, m_right_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_fin_reg, m_fin_next;

    // ---------------------------------------------------------------
    // State memory
    // ---------------------------------------------------------------
    logic               ram_we;
    logic [STATE_W-1:0] ram_wdata;
    logic [STATE_W-1:0] ram_rdata;

    logic [PHASE_BITS-1:0] step_c;
    logic [PHASE_BITS-1:0] step_b;

    assign step_c = PHASE_BITS'(carrier_step_reg);
    assign step_b = PHASE_BITS'(beat_step_reg);
    assign ram_we = (state_reg == ST_WB);

    // advance the frame and both phases on write-back
    always_comb begin
        case (wb_cnt_reg)
            ENT_FRAME:  ram_wdata = STATE_W'(frame_reg + 32'd1);
            ENT_LPHASE: ram_wdata = STATE_W'(lph_reg + step_c);
            ENT_RPHASE: ram_wdata = STATE_W'(rph_reg + step_c + step_b);
            ENT_FADE:   ram_wdata = STATE_W'(fade_reg);
            default:    ram_wdata = '0;
        endcase
    end

    btg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (ENT_COUNT)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wb_cnt_reg),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[ENT_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sine table addressing: fold the full cycle onto the quarter wave
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0]      sel_phase;
    logic [SINE_INDEX_BITS-1:0] sine_idx;
    logic [SINE_INDEX_BITS-3:0] sine_pos;
    logic [ROM_AW-1:0]          rom_addr;
    logic [SINE_MAG_BITS-1:0]   rom_rdata;
    logic                       sine_neg;

    assign sel_phase = ch_reg ? rph_reg : lph_reg;
    assign sine_idx  = sel_phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
    assign sine_pos  = sine_idx[SINE_INDEX_BITS-3:0];
    assign sine_neg  = sine_idx[SINE_INDEX_BITS-1];
    assign rom_addr  = sine_idx[SINE_INDEX_BITS-2]
                     ? ROM_AW'(QUARTER) - {1'b0, sine_pos}
                     : {1'b0, sine_pos};

    btg_sine_rom #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_sine_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .rdata (rom_rdata)
    );

    // ---------------------------------------------------------------
    // Envelope decision and divider
    // ---------------------------------------------------------------
    logic                  past_end;
    logic                  fade_on;
    logic                  fade_in;
    logic                  fade_out;
    logic                  is_last;
    logic [FRAME_BITS-1:0] fade_num;
    logic [FRAME_BITS-1:0] fade_clamped;
    logic                  div_start;
    logic [ENV_FRAC_BITS-1:0] div_quotient;
    btg_div_status_t       div_status;

    assign past_end = frame_reg >= total_frames_reg;
    assign fade_on  = (fade_reg != '0);
    assign fade_in  = fade_on && (frame_reg < fade_reg);
    assign fade_out = fade_on
                   && (({1'b0, frame_reg} + {1'b0, fade_reg}) >= {1'b0, total_frames_reg});
    assign is_last  = (frame_reg == total_frames_reg - 32'd1);
    // fade-in counts up from the start, fade-out down to the last frame
    assign fade_num = fade_in ? frame_reg : (total_frames_reg - 32'd1 - frame_reg);

    // clamp the requested fade to half the run
    assign fade_clamped = ({fade_frames_reg, 1'b0} > {1'b0, total_frames_reg})
                        ? {1'b0, total_frames_reg[FRAME_BITS-1:1]}
                        : fade_frames_reg;

    assign div_start = (state_reg == ST_CHECK) && !past_end && (fade_in || fade_out)
                    && !div_status.busy;

    btg_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (fade_num),
        .den      (fade_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // ---------------------------------------------------------------
    // Sample: magnitude product, shift, then restore the sign
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] mag_val;
    logic [SAMPLE_BITS-1:0] sample_val;

    assign mag_val    = prod2_reg[PROD2_BITS-1 -: SAMPLE_BITS];
    assign sample_val = neg_reg ? ('0 - mag_val) : mag_val;

    assign s_ready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        run_done_next  = run_done_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        wb_cnt_next    = wb_cnt_reg;
        ch_next        = ch_reg;
        frame_next     = frame_reg;
        lph_next       = lph_reg;
        rph_next       = rph_reg;
        fade_next      = fade_reg;
        env_next       = env_reg;
        neg_next       = neg_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        last_next      = last_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_last_next  = res_last_reg;
        res_fin_next   = res_fin_reg;
        m_left_next    = m_left_reg;
        m_right_next   = m_right_reg;
        m_last_next    = m_last_reg;
        m_fin_next     = m_fin_reg;

        // drop the held result once it is taken
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rd_cnt_next = '0;
                    if (s_restart) begin
                        // new run: state comes from here, no memory read
                        frame_next    = '0;
                        lph_next      = '0;
                        rph_next      = '0;
                        fade_next     = fade_clamped;
                        run_done_next = 1'b0;
                        state_next    = ST_CHECK;
                    end else if (run_done_reg) begin
                        res_left_next  = '0;
                        res_right_next = '0;
                        res_last_next  = 1'b0;
                        res_fin_next   = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ: begin
                // one entry a cycle, data lands in the cycle after its address
                rd_cnt_next  = rd_cnt_reg + 1'b1;
                rd_addr_next = rd_cnt_reg[ENT_BITS-1:0];
                if (rd_cnt_reg != '0) begin
                    case (rd_addr_reg)
                        ENT_FRAME:  frame_next = ram_rdata[FRAME_BITS-1:0];
                        ENT_LPHASE: lph_next   = ram_rdata[PHASE_BITS-1:0];
                        ENT_RPHASE: rph_next   = ram_rdata[PHASE_BITS-1:0];
                        ENT_FADE:   fade_next  = ram_rdata[FRAME_BITS-1:0];
                        default: ;
                    endcase
                end
                if (rd_cnt_reg == RD_CNT_W'(ENT_COUNT)) begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                last_next   = is_last;
                ch_next     = 1'b0;
                wb_cnt_next = '0;
                if (past_end) begin
                    // run shortened below the current frame: end it here
                    run_done_next  = 1'b1;
                    res_left_next  = '0;
                    res_right_next = '0;
                    res_last_next  = 1'b0;
                    res_fin_next   = 1'b1;
                    state_next     = ST_OUT;
                end else if (fade_in || fade_out) begin
                    state_next = ST_DIV;
                end else begin
                    env_next   = ENV_ONE;
                    state_next = ST_ROM;
                end
            end

            ST_DIV: begin
                if (div_status.done) begin
                    env_next   = {1'b0, div_quotient};
                    state_next = ST_ROM;
                end
            end

            ST_ROM: begin
                neg_next   = sine_neg;
                state_next = ST_MUL1;
            end

            ST_MUL1: begin
                prod1_next = PROD1_BITS'(rom_rdata) * PROD1_BITS'(amplitude_reg);
                state_next = ST_MUL2;
            end

            ST_MUL2: begin
                prod2_next = PROD2_BITS'(prod1_reg) * PROD2_BITS'(env_reg);
                state_next = ST_SIGN;
            end

            ST_SIGN: begin
                res_last_next = last_reg;
                res_fin_next  = 1'b0;
                if (ch_reg) begin
                    res_right_next = sample_val;
                    state_next     = ST_WB;
                end else begin
                    res_left_next = sample_val;
                    ch_next       = 1'b1;
                    state_next    = ST_ROM;
                end
            end

            ST_WB: begin
                wb_cnt_next = wb_cnt_reg + 1'b1;
                if (wb_cnt_reg == ENT_FADE) begin
                    run_done_next = last_reg;
                    state_next    = ST_OUT;
                end
            end

            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_left_next  = res_left_reg;
                    m_right_next = res_right_reg;
                    m_last_next  = res_last_reg;
                    m_fin_next   = res_fin_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_done_reg <= 1'b1;
            rd_cnt_reg   <= '0;
            wb_cnt_reg   <= '0;
            ch_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_done_reg <= run_done_next;
            rd_cnt_reg   <= rd_cnt_next;
            wb_cnt_reg   <= wb_cnt_next;
            ch_reg       <= ch_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        frame_reg     <= frame_next;
        lph_reg       <= lph_next;
        rph_reg       <= rph_next;
        fade_reg      <= fade_next;
        env_reg       <= env_next;
        neg_reg       <= neg_next;
        prod1_reg     <= prod1_next;
        prod2_reg     <= prod2_next;
        last_reg      <= last_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_last_reg  <= res_last_next;
        res_fin_reg   <= res_fin_next;
        m_left_reg    <= m_left_next;
        m_right_reg   <= m_right_next;
        m_last_reg    <= m_last_next;
        m_fin_reg     <= m_fin_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_left_sample  = signed'(m_left_reg);
    assign m_right_sample = signed'(m_right_reg);
    assign m_last_frame   = m_last_reg;
    assign m_finished     = m_fin_reg;

endmodule

### rtl/btg_checker.sv
// Port-level checks for the binaural tone generator, bound to its top level.
// Depends only on the top level's ports.
module btg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_left_sample,
    input logic signed [SAMPLE_BITS-1:0] m_right_sample,
    input logic                          m_last_frame,
    input logic                          m_finished
);

    // a stalled result holds
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_sample)
            && $stable(m_right_sample) && $stable(m_last_frame) && $stable(m_finished))
        else $error("result changed while stalled");

    // a finished frame is silent and never the last one
    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_left_sample == 0 && m_right_sample == 0
            && !m_last_frame)
        else $error("finished frame carries data");

    // one frame at a time: the request side closes right after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind binaural_tone_generator_top btg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_btg_checker (.*);
